[rtl/yrp_pkg.sv]
// Package for the YUV to RGB pixel pair converter.
// Holds widths, fixed-point coefficients and the word and stage types.
// No dependencies.
`default_nettype none

package yrp_pkg;

  localparam int SAMPLE_W  = 14;
  localparam int DEPTH_W   = 4;
  localparam int DOWN_W    = 3;
  localparam int RGB_W     = 8;
  localparam int FRAC_BITS = 10;

  localparam logic [DEPTH_W-1:0] DEPTH_MIN = 4'd8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 4'd14;
  localparam logic [DEPTH_W-1:0] DEPTH_RST = 4'd8;

  // centered chroma, one bit above a sample
  localparam int CHROMA_W = SAMPLE_W + 1;
  // coefficients are below 2^(FRAC_BITS+1), plus a sign bit
  localparam int CO_W     = FRAC_BITS + 2;
  localparam int PROD_W   = CHROMA_W + CO_W + 1;
  // luma plus a scaled chroma term, signed
  localparam int CH_W     = SAMPLE_W + 3;

  localparam logic signed [CO_W-1:0] COEF_RV = CO_W'((1403 << FRAC_BITS) / 1000);
  localparam logic signed [CO_W-1:0] COEF_GU = CO_W'((344 << FRAC_BITS) / 1000);
  localparam logic signed [CO_W-1:0] COEF_GV = CO_W'((714 << FRAC_BITS) / 1000);
  localparam logic signed [CO_W-1:0] COEF_BU = CO_W'((1770 << FRAC_BITS) / 1000);

  localparam logic [RGB_W-1:0] RGB_MAX = 8'd255;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma_first;
    logic [SAMPLE_W-1:0] luma_second;
    logic [SAMPLE_W-1:0] chroma_blue;
    logic [SAMPLE_W-1:0] chroma_red;
  } yuv_pair_t;

  typedef struct packed {
    logic [RGB_W-1:0] red_first;
    logic [RGB_W-1:0] green_first;
    logic [RGB_W-1:0] blue_first;
    logic [RGB_W-1:0] red_second;
    logic [RGB_W-1:0] green_second;
    logic [RGB_W-1:0] blue_second;
  } rgb_pair_t;

  // control that travels with every stage
  typedef struct packed {
    logic              valid;
    logic [DOWN_W-1:0] down;
  } ctl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]        y0;
    logic [SAMPLE_W-1:0]        y1;
    logic signed [CHROMA_W-1:0] u;
    logic signed [CHROMA_W-1:0] v;
  } front_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      y0;
    logic [SAMPLE_W-1:0]      y1;
    logic signed [PROD_W-1:0] pr;
    logic signed [PROD_W-1:0] pgu;
    logic signed [PROD_W-1:0] pgv;
    logic signed [PROD_W-1:0] pb;
  } prod_t;

  typedef struct packed {
    logic signed [CH_W-1:0] r0;
    logic signed [CH_W-1:0] g0;
    logic signed [CH_W-1:0] b0;
    logic signed [CH_W-1:0] r1;
    logic signed [CH_W-1:0] g1;
    logic signed [CH_W-1:0] b1;
  } chan_t;

endpackage

`default_nettype wire

[rtl/yrp_front.sv]
// Stage 1: masks samples to the sample depth and centers chroma.
// Depends on yrp_pkg.
`default_nettype none

module yrp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [yrp_pkg::DEPTH_W-1:0] depth_i,
  input  yrp_pkg::yuv_pair_t          pair_i,
  output yrp_pkg::ctl_t               ctl_o,
  output yrp_pkg::front_t             data_o
);
  import yrp_pkg::*;

  logic [SAMPLE_W:0]          one_sh;
  logic [SAMPLE_W-1:0]        mask;
  logic signed [CHROMA_W-1:0] offs;
  ctl_t                       ctl_d, ctl_q;
  front_t                     data_d, data_q;

  always_comb begin
    one_sh = (SAMPLE_W + 1)'(1) << depth_i;
    mask   = SAMPLE_W'(one_sh - 1'b1);
    offs   = CHROMA_W'(one_sh >> 1);
    data_d.y0 = pair_i.luma_first  & mask;
    data_d.y1 = pair_i.luma_second & mask;
    data_d.u  = $signed({1'b0, pair_i.chroma_blue & mask}) - offs;
    data_d.v  = $signed({1'b0, pair_i.chroma_red  & mask}) - offs;
    ctl_d.valid = valid_i;
    ctl_d.down  = DOWN_W'(depth_i - DEPTH_MIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign ctl_o  = ctl_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

[rtl/yrp_mult.sv]
// Stage 2: the four chroma by coefficient products, registered.
// Depends on yrp_pkg.
`default_nettype none

module yrp_mult (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  yrp_pkg::ctl_t   ctl_i,
  input  yrp_pkg::front_t data_i,
  output yrp_pkg::ctl_t   ctl_o,
  output yrp_pkg::prod_t  data_o
);
  import yrp_pkg::*;

  ctl_t  ctl_q;
  prod_t data_d, data_q;

  always_comb begin
    data_d.y0  = data_i.y0;
    data_d.y1  = data_i.y1;
    data_d.pr  = data_i.v * COEF_RV;
    data_d.pgu = data_i.u * COEF_GU;
    data_d.pgv = data_i.v * COEF_GV;
    data_d.pb  = data_i.u * COEF_BU;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign ctl_o  = ctl_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

[rtl/yrp_mix.sv]
// Stage 3: scales the products back and adds them to both luma samples.
// Depends on yrp_pkg.
`default_nettype none

module yrp_mix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  yrp_pkg::ctl_t  ctl_i,
  input  yrp_pkg::prod_t data_i,
  output yrp_pkg::ctl_t  ctl_o,
  output yrp_pkg::chan_t data_o
);
  import yrp_pkg::*;

  logic signed [PROD_W-1:0] pg_sum;
  logic signed [CH_W-1:0]   cr, cg, cb, y0, y1;
  ctl_t                     ctl_q;
  chan_t                    data_d, data_q;

  always_comb begin
    pg_sum = data_i.pgu + data_i.pgv;
    cr = CH_W'(data_i.pr >>> FRAC_BITS);
    cg = CH_W'(pg_sum    >>> FRAC_BITS);
    cb = CH_W'(data_i.pb >>> FRAC_BITS);
    y0 = $signed({{(CH_W - SAMPLE_W){1'b0}}, data_i.y0});
    y1 = $signed({{(CH_W - SAMPLE_W){1'b0}}, data_i.y1});
    data_d.r0 = y0 + cr;
    data_d.g0 = y0 - cg;
    data_d.b0 = y0 + cb;
    data_d.r1 = y1 + cr;
    data_d.g1 = y1 - cg;
    data_d.b1 = y1 + cb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign ctl_o  = ctl_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

[rtl/yrp_sat.sv]
// Stage 4: shifts each channel down to eight bits and clamps to 0..255.
// Depends on yrp_pkg.
`default_nettype none

module yrp_sat (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  yrp_pkg::ctl_t      ctl_i,
  input  yrp_pkg::chan_t     data_i,
  output logic               valid_o,
  output yrp_pkg::rgb_pair_t rgb_o
);
  import yrp_pkg::*;

  logic      valid_q;
  rgb_pair_t rgb_d, rgb_q;

  function automatic logic [RGB_W-1:0] clamp8(logic signed [CH_W-1:0] ch,
                                              logic [DOWN_W-1:0] down);
    logic signed [CH_W-1:0] sh;
    sh = ch >>> down;
    if (sh < 0) begin
      return '0;
    end else if (sh > $signed({1'b0, RGB_MAX})) begin
      return RGB_MAX;
    end else begin
      return sh[RGB_W-1:0];
    end
  endfunction

  always_comb begin
    rgb_d.red_first    = clamp8(data_i.r0, ctl_i.down);
    rgb_d.green_first  = clamp8(data_i.g0, ctl_i.down);
    rgb_d.blue_first   = clamp8(data_i.b0, ctl_i.down);
    rgb_d.red_second   = clamp8(data_i.r1, ctl_i.down);
    rgb_d.green_second = clamp8(data_i.g1, ctl_i.down);
    rgb_d.blue_second  = clamp8(data_i.b1, ctl_i.down);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

`default_nettype wire

[rtl/yuv_to_rgb_pixel_pair_top.sv]
// Top level of the YUV to RGB pixel pair converter.
// Depends on yrp_pkg, yrp_front, yrp_mult, yrp_mix and yrp_sat.
//
// Converts one word per clock: two adjacent luma samples and their shared
// U/V pair become two 8-bit RGB triples (BT.601 style, 10-bit fixed point
// coefficients). A word is taken at every rising edge with start high;
// busy is always low, so a new word may follow in the very next cycle.
// Each result passes through the four register stages (mask/center,
// multiply, add, shift/clamp) and sits on rgb_o for one cycle with
// rgb_valid_o high. The receiver cannot hold results off, and results
// come out in the order words went in.
// sample_depth (8..14, reset 8) is written through cfg_we_i/cfg_wdata_i;
// values outside the range clamp on write. Write it only while no word is
// in flight.
`default_nettype none

module yuv_to_rgb_pixel_pair_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  yrp_pkg::yuv_pair_t          pair_i,
  output logic                        rgb_valid_o,
  output yrp_pkg::rgb_pair_t          rgb_o,
  input  logic                        cfg_we_i,
  input  logic [yrp_pkg::DEPTH_W-1:0] cfg_wdata_i
);
  import yrp_pkg::*;

  logic [DEPTH_W-1:0] depth_d, depth_q;
  ctl_t               s1_ctl, s2_ctl, s3_ctl;
  front_t             s1_data;
  prod_t              s2_data;
  chan_t              s3_data;

  // Pipeline never stalls, so the block is never busy.
  assign busy = 1'b0;

  // Depth register, clamped into 8..14 on write.
  always_comb begin
    depth_d = depth_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i < DEPTH_MIN) begin
        depth_d = DEPTH_MIN;
      end else if (cfg_wdata_i > DEPTH_MAX) begin
        depth_d = DEPTH_MAX;
      end else begin
        depth_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RST;
    end else begin
      depth_q <= depth_d;
    end
  end

  // Stage 1: mask to depth, center chroma; down-shift rides along.
  yrp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .depth_i (depth_q),
    .pair_i  (pair_i),
    .ctl_o   (s1_ctl),
    .data_o  (s1_data)
  );

  // Stage 2: four chroma products.
  yrp_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (s1_ctl),
    .data_i (s1_data),
    .ctl_o  (s2_ctl),
    .data_o (s2_data)
  );

  // Stage 3: scale back and add to luma, six channels.
  yrp_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (s2_ctl),
    .data_i (s2_data),
    .ctl_o  (s3_ctl),
    .data_o (s3_data)
  );

  // Stage 4: down-shift and clamp into the output register.
  yrp_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s3_ctl),
    .data_i  (s3_data),
    .valid_o (rgb_valid_o),
    .rgb_o   (rgb_o)
  );

endmodule

`default_nettype wire

[rtl/yrp_checker.sv]
// Port-level checker for the YUV to RGB pixel pair converter, with its bind.
// Depends on yuv_to_rgb_pixel_pair_top.
`default_nettype none

module yrp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic rgb_valid_o
);

  // every word taken gives a result
  a_word_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 rgb_valid_o)
    else $error("word taken but no result four cycles later");

  // no result without a word taken earlier
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_valid_o |-> $past(start && !busy, 4))
    else $error("result without a matching word");

  // the pipeline never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

endmodule

bind yuv_to_rgb_pixel_pair_top yrp_checker u_yrp_checker (.*);

`default_nettype wire

[tb/tb_yuv_to_rgb_pixel_pair_top.sv]
// Self-checking testbench for yuv_to_rgb_pixel_pair_top.
// Depends on yrp_pkg and the converter RTL; drives words from a queue and
// checks every RGB word against a BT.601 fixed-point predictor.
module tb_yuv_to_rgb_pixel_pair_top;
  timeunit 1ns;
  timeprecision 1ps;

  import yrp_pkg::*;

  // fixed-point chroma coefficients, 10 fractional bits, truncated
  localparam int FRAC = 10;
  localparam int K_RV = 1436;  // 1.403
  localparam int K_GU = 352;   // 0.344
  localparam int K_GV = 731;   // 0.714
  localparam int K_BU = 1812;  // 1.770

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  yuv_pair_t           pair_word = '0;
  logic                rgb_valid_o;
  rgb_pair_t           rgb_o;
  logic                cfg_we_i = 1'b0;
  logic [DEPTH_W-1:0]  cfg_wdata_i = '0;

  // words waiting to go in, RGB words waiting to come out
  yuv_pair_t pending_pairs[$];
  rgb_pair_t expected_rgb[$];

  logic [DEPTH_W-1:0] depth_model = DEPTH_RST;
  int  idle_pct       = 21;
  bit  taken          = 1'b0;
  int  queued_count   = 0;
  int  accepted_count = 0;
  int  mismatch_count = 0;
  int  cycle_count    = 0;

  yuv_to_rgb_pixel_pair_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pair_i      (pair_word),
    .rgb_valid_o (rgb_valid_o),
    .rgb_o       (rgb_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [RGB_W-1:0] clamp8(int x);
    if (x < 0) return '0;
    if (x > 255) return 8'd255;
    return RGB_W'(x);
  endfunction

  // stored depth saturates into 8..14 on write
  function automatic logic [DEPTH_W-1:0] clamp_depth(logic [DEPTH_W-1:0] raw);
    if (raw < DEPTH_MIN) return DEPTH_MIN;
    if (raw > DEPTH_MAX) return DEPTH_MAX;
    return raw;
  endfunction

  function automatic rgb_pair_t bt601_convert(yuv_pair_t w, logic [DEPTH_W-1:0] d);
    int mask, half, down;
    int y0, y1, u, v, cr, cg, cb;
    rgb_pair_t r;
    mask = (1 << d) - 1;
    half = 1 << (int'(d) - 1);
    down = int'(d) - 8;
    // sample bits above the depth are dropped
    y0 = int'(w.luma_first) & mask;
    y1 = int'(w.luma_second) & mask;
    u  = (int'(w.chroma_blue) & mask) - half;
    v  = (int'(w.chroma_red) & mask) - half;
    // arithmetic shifts floor toward minus infinity
    cr = (K_RV * v) >>> FRAC;
    cg = (K_GU * u + K_GV * v) >>> FRAC;
    cb = (K_BU * u) >>> FRAC;
    r.red_first    = clamp8((y0 + cr) >>> down);
    r.green_first  = clamp8((y0 - cg) >>> down);
    r.blue_first   = clamp8((y0 + cb) >>> down);
    r.red_second   = clamp8((y1 + cr) >>> down);
    r.green_second = clamp8((y1 - cg) >>> down);
    r.blue_second  = clamp8((y1 + cb) >>> down);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: inputs move on the falling edge only
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    // a word on the bus stays until it has been taken
    if (!start || taken) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        pair_word <= pending_pairs.pop_front();
        start     <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: sample on the rising edge, before the DUT's registers move
  // ---------------------------------------------------------------------
  task automatic check_channel(string name, logic [RGB_W-1:0] want, logic [RGB_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    rgb_pair_t want;
    cycle_count++;
    taken = start && !busy;
    // push before pop so a result that came out with its own word would still find it
    if (rst_ni && taken) begin
      expected_rgb.push_back(bt601_convert(pair_word, depth_model));
      accepted_count++;
    end
    if (rst_ni && rgb_valid_o === 1'b1) begin
      if (expected_rgb.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: RGB word with none expected: %h", $realtime, rgb_o);
      end else begin
        want = expected_rgb.pop_front();
        check_channel("red_first",    want.red_first,    rgb_o.red_first);
        check_channel("green_first",  want.green_first,  rgb_o.green_first);
        check_channel("blue_first",   want.blue_first,   rgb_o.blue_first);
        check_channel("red_second",   want.red_second,   rgb_o.red_second);
        check_channel("green_second", want.green_second, rgb_o.green_second);
        check_channel("blue_second",  want.blue_second,  rgb_o.blue_second);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic send_pair(int y0, int y1, int u, int v);
    yuv_pair_t w;
    w.luma_first  = SAMPLE_W'(y0);
    w.luma_second = SAMPLE_W'(y1);
    w.chroma_blue = SAMPLE_W'(u);
    w.chroma_red  = SAMPLE_W'(v);
    pending_pairs.push_back(w);
    queued_count++;
  endtask

  // all queued words taken and all their RGB words seen
  task automatic wait_drained();
    while (!(accepted_count == queued_count && expected_rgb.size() == 0))
      @(negedge clk_i);
  endtask

  // only called while drained
  task automatic write_depth(logic [DEPTH_W-1:0] raw);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= raw;
    depth_model = clamp_depth(raw);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // extremes at the current depth: saturation both ways, neutral chroma,
  // and samples whose bits above the depth must be ignored
  task automatic send_corners();
    int m, h, hi;
    m  = (1 << depth_model) - 1;
    h  = 1 << (int'(depth_model) - 1);
    hi = 16383 & ~m;
    send_pair(0, m, h, h);
    send_pair(0, 0, 0, 0);
    send_pair(m, m, m, m);
    send_pair(h, h, 0, 0);
    send_pair(h, h, m, m);
    send_pair(h, h, 0, m);
    send_pair(h, h, m, 0);
    send_pair(m, m, h, m);
    send_pair(0, 0, h, 0);
    send_pair(0, m, m, 0);
    send_pair(m, 0, 0, m);
    send_pair(hi, hi, hi, hi);
    send_pair(16383, 16383, 16383, 16383);
  endtask

  function automatic int pick_sample(bit is_chroma);
    int m, h;
    m = (1 << depth_model) - 1;
    h = 1 << (int'(depth_model) - 1);
    case ($urandom_range(5))
      0, 1: return $urandom_range(16383);
      2:    return $urandom_range(16383) & m;
      3:    return $urandom_range(1) ? m : 0;
      4:    return is_chroma ? (h + $urandom_range(64) - 32) & m : $urandom_range(m);
      default: return $urandom_range(1) ? 16383 : ($urandom_range(16383) | m);
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count)
      send_pair(pick_sample(0), pick_sample(0), pick_sample(1), pick_sample(1));
  endtask

  // ---------------------------------------------------------------------
  // Sequence: reset, directed corners, then random phases per depth
  // ---------------------------------------------------------------------
  initial begin
    logic [DEPTH_W-1:0] depths[10];
    depths = '{4'd0, 4'd14, 4'd9, 4'd7, 4'd12, 4'd11, 4'd13, 4'd10, 4'd8, 4'd15};

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset depth is 8
    send_corners();
    wait_drained();
    // out-of-range write clamps to 14
    write_depth(4'd15);
    send_corners();
    wait_drained();

    foreach (depths[i]) begin
      write_depth(depths[i]);
      // one phase runs back to back with no gaps at all
      idle_pct = (i == 2) ? 0 : 21;
      send_random((i == 2) ? 300 : 135);
      wait_drained();
    end

    // catch any stray RGB word past the pipeline depth
    repeat (12) @(negedge clk_i);
    if (mismatch_count == 0 && expected_rgb.size() == 0) begin
      $display("tb_yuv_to_rgb_pixel_pair_top OK");
    end else begin
      $display("tb_yuv_to_rgb_pixel_pair_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_yuv_to_rgb_pixel_pair_top NOT OK");
    $finish;
  end

endmodule
